// ===== design/sorted_list_insert_defines.svh =====
// Assertion macros shared by the sorted list blocks.
// Each macro samples on clock and is disabled while reset is high.
`ifndef SORTED_LIST_INSERT_DEFINES_SVH
`define SORTED_LIST_INSERT_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SLI_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sli_pkg.sv =====
`timescale 1ns / 1ps

package sli_pkg;

   // Command codes carried in the request beat
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   // Completion codes carried in the response beat
   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_FULL  = 2'd1,
      STS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [31:0] value;
      logic [3:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [3:0]         position;
      logic [4:0]         entry_count;
      status_type         status;
   } rsp_type;

   // Source of the next scan/shift pointer (also the RAM read address)
   typedef enum logic [2:0] {
      PTR_HOLD = 3'd0,
      PTR_ZERO = 3'd1,
      PTR_IDX  = 3'd2,
      PTR_INC  = 3'd3,
      PTR_DEC  = 3'd4,
      PTR_LAST = 3'd5
   } ptr_sel_type;

   // Source of the placement position
   typedef enum logic [1:0] {
      POS_HOLD  = 2'd0,
      POS_PTR   = 2'd1,
      POS_COUNT = 2'd2,
      POS_ZERO  = 2'd3
   } pos_sel_type;

   // RAM write source
   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_SHIFT = 2'd1,
      WR_PLACE = 2'd2
   } wr_sel_type;

   // Kind of response beat to issue
   typedef enum logic [2:0] {
      RSP_NONE     = 3'd0,
      RSP_CLEAR    = 3'd1,
      RSP_FULL     = 3'd2,
      RSP_PLACED   = 3'd3,
      RSP_READ_OK  = 3'd4,
      RSP_READ_BAD = 3'd5
   } rsp_kind_type;

   // Controller to datapath commands
   typedef struct packed {
      logic         load;
      ptr_sel_type  ptr_sel;
      pos_sel_type  pos_sel;
      logic         prev_load;
      wr_sel_type   wr_sel;
      logic         clear;
      rsp_kind_type rsp_kind;
   } ctl_type;

   // Datapath to controller status
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    idx_bad;
      logic    hit;
      logic    last;
      logic    at_pos;
   } sts_type;

endpackage

// ===== design/sorted_list_insert.sv =====
`timescale 1ns / 1ps
// Sorted list insert: a bounded ordered table of signed 32-bit values.
// Request channel: drive req_payload and raise start; the beat is taken at
// a rising edge with start high and busy low. Commands: clear, append at
// tail, sorted insert, read entry at index.
// Response channel: rsp_strobe is high for exactly one cycle with the result
// on rsp_payload; the receiver cannot stall and must take it that cycle.
// Sequence after the accepting edge: clear, a refused insert/append and a
//   read respond from the execute state; append, and an insert into an
//   empty table, go on to the place state. A sorted insert scans entries
//   from the head until the placement rule matches, moves the entries from
//   the tail down to that position up by one, then places the value; the
//   entries scanned plus the entries moved are at most the count + 1.
// The entries live in one single-port-write, registered-read RAM, so the scan
// reads one entry per cycle and each shift step moves one entry per cycle.
// One command is in flight at a time; busy stays high until the strobe cycle,
// and a new beat may be accepted in the same cycle the strobe is shown.
// Reset (synchronous, active high) empties the table and drops any pending
// response; RAM contents are not cleared and are never read before written.
module sorted_list_insert #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sli_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output sli_pkg::rsp_type rsp_payload
);

   sli_pkg::ctl_type ctl;
   sli_pkg::sts_type sts;

   sli_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_payload.command),
      .sts         (sts),
      .busy        (busy),
      .ctl         (ctl)
   );

   sli_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/sli_ram.sv =====
`timescale 1ns / 1ps

module sli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sli_datapath.sv =====
`timescale 1ns / 1ps
`include "sorted_list_insert_defines.svh"

module sli_datapath #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  sli_pkg::req_type req_payload,
   input  sli_pkg::ctl_type ctl,
   output sli_pkg::sts_type sts,
   output logic             rsp_strobe,
   output sli_pkg::rsp_type rsp_payload
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (AW > 4) ? AW : 4;
   localparam int OW = (CW > 5) ? CW : 5;
   localparam int IW = (CW > 4) ? CW : 4;

   sli_pkg::cmd_type   cmd_ff;
   logic signed [31:0] value_ff;
   logic [3:0]         idx_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic signed [31:0] prev_ff;
   logic               rsp_strobe_ff;
   sli_pkg::rsp_type   rsp_ff, rsp_in;

   logic [XW-1:0]      idx_wide;
   logic [AW-1:0]      idx_addr;
   logic [CW-1:0]      count_m1;
   logic [AW-1:0]      last_addr;
   logic [AW-1:0]      count_addr;
   logic [XW-1:0]      pos_wide;
   logic [OW-1:0]      count_wide;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [31:0]        rd_data;
   logic signed [31:0] rd_value;

   // Address helpers
   assign idx_wide   = XW'(req_payload.index);
   assign idx_addr   = idx_wide[AW-1:0];
   assign count_m1   = count_ff - CW'(1);
   assign last_addr  = count_m1[AW-1:0];
   assign count_addr = count_ff[AW-1:0];
   assign rd_value   = rd_data;

   // Select next pointer; the pointer doubles as the read address
   always_comb begin
      case (ctl.ptr_sel)
         sli_pkg::PTR_ZERO: ptr_in = '0;
         sli_pkg::PTR_IDX:  ptr_in = idx_addr;
         sli_pkg::PTR_INC:  ptr_in = ptr_ff + AW'(1);
         sli_pkg::PTR_DEC:  ptr_in = ptr_ff - AW'(1);
         sli_pkg::PTR_LAST: ptr_in = last_addr;
         default:           ptr_in = ptr_ff;
      endcase
   end

   // Select placement position
   always_comb begin
      case (ctl.pos_sel)
         sli_pkg::POS_PTR:   pos_in = ptr_ff;
         sli_pkg::POS_COUNT: pos_in = count_addr;
         sli_pkg::POS_ZERO:  pos_in = '0;
         default:            pos_in = pos_ff;
      endcase
   end

   // Drive the RAM write port: shift moves an entry up, place drops the value in
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = value_ff;
      case (ctl.wr_sel)
         sli_pkg::WR_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + AW'(1);
            wr_data = rd_data;
         end
         sli_pkg::WR_PLACE: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Advance the entry count
   always_comb begin
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.wr_sel == sli_pkg::WR_PLACE) begin
         count_in = count_ff + CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Build the response beat
   assign pos_wide   = XW'(pos_ff);
   assign count_wide = OW'(count_in);

   always_comb begin
      rsp_in.read_value  = '0;
      rsp_in.position    = '0;
      rsp_in.entry_count = count_wide[4:0];
      rsp_in.status      = sli_pkg::STS_DONE;
      case (ctl.rsp_kind)
         sli_pkg::RSP_FULL: begin
            rsp_in.status = sli_pkg::STS_FULL;
         end
         sli_pkg::RSP_PLACED: begin
            rsp_in.position = pos_wide[3:0];
         end
         sli_pkg::RSP_READ_OK: begin
            rsp_in.read_value = rd_value;
            rsp_in.position   = idx_ff;
         end
         sli_pkg::RSP_READ_BAD: begin
            rsp_in.position = idx_ff;
            rsp_in.status   = sli_pkg::STS_RANGE;
         end
         default: begin
            rsp_in.status = sli_pkg::STS_DONE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= (ctl.rsp_kind != sli_pkg::RSP_NONE);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_payload.command;
         value_ff <= req_payload.value;
         idx_ff   <= req_payload.index;
      end
      if (ctl.prev_load) begin
         prev_ff <= rd_value;
      end
      if (ctl.rsp_kind != sli_pkg::RSP_NONE) begin
         rsp_ff <= rsp_in;
      end
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
   end

   sli_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_in),
      .rd_data (rd_data)
   );

   // Status back to the controller
   always_comb begin
      sts.cmd     = cmd_ff;
      sts.full    = (count_ff == CW'(DEPTH));
      sts.empty   = (count_ff == '0);
      sts.idx_bad = (IW'(idx_ff) >= IW'(count_ff));
      sts.hit     = (ptr_ff == '0) ? (rd_value > value_ff)
                                   : !((value_ff > prev_ff) && (value_ff > rd_value));
      sts.last    = ((CW'(ptr_ff) + CW'(1)) == count_ff);
      sts.at_pos  = (ptr_ff == pos_ff);
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   `SLI_ASSERT_IMP(a_count_bounded, 1'b1, count_ff <= CW'(DEPTH), "entry count above depth")
   `SLI_ASSERT_IMP(a_shift_above_pos, ctl.wr_sel == sli_pkg::WR_SHIFT, ptr_ff >= pos_ff,
                   "shift below placement position")
   `SLI_ASSERT_NEXT(a_place_counts, ctl.wr_sel == sli_pkg::WR_PLACE,
                    count_ff == $past(count_ff) + CW'(1), "placement did not bump count")

endmodule

// ===== design/sli_controller.sv =====
`timescale 1ns / 1ps
`include "sorted_list_insert_defines.svh"

module sli_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sli_pkg::cmd_type req_command,
   input  sli_pkg::sts_type sts,
   output logic             busy,
   output sli_pkg::ctl_type ctl
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_PLACE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Sequence one command
   always_comb begin
      state_in      = state_ff;
      ctl.load      = 1'b0;
      ctl.ptr_sel   = sli_pkg::PTR_HOLD;
      ctl.pos_sel   = sli_pkg::POS_HOLD;
      ctl.prev_load = 1'b0;
      ctl.wr_sel    = sli_pkg::WR_NONE;
      ctl.clear     = 1'b0;
      ctl.rsp_kind  = sli_pkg::RSP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load    = 1'b1;
               ctl.ptr_sel = (req_command == sli_pkg::CMD_READ) ? sli_pkg::PTR_IDX
                                                                : sli_pkg::PTR_ZERO;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (sts.cmd) inside
               sli_pkg::CMD_CLEAR: begin
                  ctl.clear    = 1'b1;
                  ctl.rsp_kind = sli_pkg::RSP_CLEAR;
                  state_in     = S_IDLE;
               end
               sli_pkg::CMD_APPEND, sli_pkg::CMD_INSERT: begin
                  if (sts.full) begin
                     ctl.rsp_kind = sli_pkg::RSP_FULL;
                     state_in     = S_IDLE;
                  end else if (sts.cmd == sli_pkg::CMD_APPEND) begin
                     ctl.pos_sel = sli_pkg::POS_COUNT;
                     state_in    = S_PLACE;
                  end else if (sts.empty) begin
                     ctl.pos_sel = sli_pkg::POS_ZERO;
                     state_in    = S_PLACE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               sli_pkg::CMD_READ: begin
                  ctl.rsp_kind = sts.idx_bad ? sli_pkg::RSP_READ_BAD
                                             : sli_pkg::RSP_READ_OK;
                  state_in     = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            // walk forward until the placement rule matches
            ctl.prev_load = 1'b1;
            if (sts.hit) begin
               ctl.pos_sel = sli_pkg::POS_PTR;
               ctl.ptr_sel = sli_pkg::PTR_LAST;
               state_in    = S_SHIFT;
            end else if (sts.last) begin
               ctl.pos_sel = sli_pkg::POS_COUNT;
               state_in    = S_PLACE;
            end else begin
               ctl.ptr_sel = sli_pkg::PTR_INC;
            end
         end
         S_SHIFT: begin
            // move entries up from the tail down to the placement position
            ctl.wr_sel = sli_pkg::WR_SHIFT;
            if (sts.at_pos) begin
               state_in = S_PLACE;
            end else begin
               ctl.ptr_sel = sli_pkg::PTR_DEC;
            end
         end
         S_PLACE: begin
            ctl.wr_sel   = sli_pkg::WR_PLACE;
            ctl.rsp_kind = sli_pkg::RSP_PLACED;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `SLI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `SLI_ASSERT_NEXT(a_rsp_to_idle, ctl.rsp_kind != sli_pkg::RSP_NONE, state_ff == S_IDLE,
                    "response issued without returning to idle")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int TABLE_DEPTH = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
   localparam int REPORT_MAX = 10;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   sli_pkg::req_type req_payload;
   logic             rsp_strobe;
   sli_pkg::rsp_type rsp_payload;

   // Shadow copy of the table
   logic signed [31:0] shadow_entries [TABLE_DEPTH];
   int                 shadow_count;

   sli_pkg::rsp_type pending_rsp [$];
   int               mismatch_count;
   int               send_idle_pct;
   int               stall_cycles;

   sorted_list_insert #(
      .DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Sorted slot for a value: below entry 0 goes first, else the first slot
   // whose neighbors do not both sit below the value, else the tail.
   function automatic int sorted_slot(logic signed [31:0] v);
      int i;
      if (shadow_count == 0 || shadow_entries[0] > v)
         return 0;
      for (i = 1; i < shadow_count; i++) begin
         if (!(v > shadow_entries[i - 1] && v > shadow_entries[i]))
            return i;
      end
      return shadow_count;
   endfunction

   // Apply one command to the shadow table and return the response it causes
   function automatic sli_pkg::rsp_type table_apply(sli_pkg::req_type beat);
      sli_pkg::rsp_type r;
      int               pos;
      int               k;
      r = '0;
      r.status = sli_pkg::STS_DONE;
      case (beat.command) inside
         sli_pkg::CMD_CLEAR: begin
            shadow_count = 0;
         end
         sli_pkg::CMD_APPEND, sli_pkg::CMD_INSERT: begin
            if (shadow_count >= TABLE_DEPTH) begin
               r.status = sli_pkg::STS_FULL;
            end else begin
               pos = (beat.command == sli_pkg::CMD_APPEND) ? shadow_count
                                                           : sorted_slot(beat.value);
               for (k = shadow_count; k > pos; k--)
                  shadow_entries[k] = shadow_entries[k - 1];
               shadow_entries[pos] = beat.value;
               shadow_count++;
               r.position = pos[3:0];
            end
         end
         default: begin
            r.position = beat.index;
            if (int'(beat.index) >= shadow_count)
               r.status = sli_pkg::STS_RANGE;
            else
               r.read_value = shadow_entries[beat.index];
         end
      endcase
      r.entry_count = shadow_count[4:0];
      return r;
   endfunction

   function automatic sli_pkg::req_type make_beat(sli_pkg::cmd_type cmd,
                                                  logic signed [31:0] v, int idx);
      sli_pkg::req_type b;
      b.command = cmd;
      b.value = v;
      b.index = idx[3:0];
      return b;
   endfunction

   // Many small values so that ties and near ties are common
   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0, 1, 2, 3: return $urandom_range(16) - 8;
         4: return 32'sh8000_0000;
         5: return 32'sh7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Present one beat, with random idle cycles ahead of it, and record the
   // expected response once the block takes it
   task automatic send_beat(sli_pkg::req_type beat);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         req_payload <= make_beat(sli_pkg::cmd_type'($urandom_range(3)), $urandom,
                                  $urandom_range(15));
         @(negedge clock);
      end
      start <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_rsp.push_back(table_apply(beat));
   endtask

   // Drop start and hold off until every outstanding response is back
   task automatic hold_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_beat(make_beat(sli_pkg::CMD_CLEAR, 0, 0));
      send_beat(make_beat(sli_pkg::CMD_READ, 0, 0));
      send_beat(make_beat(sli_pkg::CMD_READ, 0, 15));
      send_beat(make_beat(sli_pkg::CMD_INSERT, 100, 0));
   endtask

   task automatic test_sorted_placement();
      send_beat(make_beat(sli_pkg::CMD_INSERT, -50, 0));
      send_beat(make_beat(sli_pkg::CMD_INSERT, 32'sh7fff_ffff, 0));
      send_beat(make_beat(sli_pkg::CMD_INSERT, 100, 0));
      send_beat(make_beat(sli_pkg::CMD_INSERT, 32'sh8000_0000, 0));
      send_beat(make_beat(sli_pkg::CMD_INSERT, 0, 0));
      send_beat(make_beat(sli_pkg::CMD_APPEND, -1, 0));
      send_beat(make_beat(sli_pkg::CMD_INSERT, 8, 0));
      send_beat(make_beat(sli_pkg::CMD_READ, 0, 0));
      send_beat(make_beat(sli_pkg::CMD_READ, 0, shadow_count - 1));
      send_beat(make_beat(sli_pkg::CMD_READ, 0, shadow_count));
   endtask

   // Fill with extreme and alternating bit patterns, then check refusals on a full table
   task automatic test_full_table();
      logic signed [31:0] patterns [4];
      int                 i;
      patterns[0] = 32'sh8000_0000;
      patterns[1] = 32'sh7fff_ffff;
      patterns[2] = 32'sh5555_5555;
      patterns[3] = 32'shaaaa_aaaa;
      send_beat(make_beat(sli_pkg::CMD_CLEAR, 0, 0));
      for (i = 0; i < TABLE_DEPTH; i++)
         send_beat(make_beat(sli_pkg::CMD_APPEND, patterns[i % 4] ^ i, 0));
      send_beat(make_beat(sli_pkg::CMD_APPEND, 1, 0));
      send_beat(make_beat(sli_pkg::CMD_INSERT, 1, 0));
      send_beat(make_beat(sli_pkg::CMD_READ, 0, 15));
      send_beat(make_beat(sli_pkg::CMD_READ, 0, 0));
   endtask

   // Random traffic: mostly inserts and in-range reads that build the table
   // up, with occasional clears, appends and out-of-range reads
   task automatic test_random_traffic(int n_items, int idle_pct);
      int               n;
      int               sel;
      int               idx;
      sli_pkg::cmd_type cmd;
      send_idle_pct = idle_pct;
      for (n = 0; n < n_items; n++) begin
         if (n == n_items / 2)
            hold_until_drained();
         sel = $urandom_range(99);
         if (sel < 4 || (shadow_count == TABLE_DEPTH && sel < 25))
            cmd = sli_pkg::CMD_CLEAR;
         else if (sel < 25)
            cmd = sli_pkg::CMD_APPEND;
         else if (sel < 68)
            cmd = sli_pkg::CMD_INSERT;
         else
            cmd = sli_pkg::CMD_READ;
         if (shadow_count > 0 && $urandom_range(9) < 8)
            idx = $urandom_range(shadow_count - 1);
         else
            idx = $urandom_range(15);
         send_beat(make_beat(cmd, pick_value(), idx));
      end
   endtask

   task automatic report_mismatch(string what, sli_pkg::rsp_type want,
                                  sli_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%s: expected v=%0d p=%0d n=%0d s=%0d, got v=%0d p=%0d n=%0d s=%0d",
                  what, want.read_value, want.position, want.entry_count, want.status,
                  got.read_value, got.position, got.entry_count, got.status);
   endtask

   // Check each response beat against the oldest expectation
   always @(posedge clock) begin : rsp_check
      sli_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_payload);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.read_value !== want.read_value ||
                rsp_payload.position !== want.position ||
                rsp_payload.entry_count !== want.entry_count ||
                rsp_payload.status !== want.status)
               report_mismatch("response mismatch", want, rsp_payload);
         end
      end
   end

   // Stop the run if no beat moves in either direction for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      shadow_count = 0;
      mismatch_count = 0;
      send_idle_pct = 0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         shadow_entries[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_sorted_placement();
      test_full_table();
      test_random_traffic(260, 24);
      test_random_traffic(260, 47);
      test_random_traffic(260, 0);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
